>>> design/spiral_matrix_readout_assert.svh
// Assertion macros for the spiral matrix readout.
// Each macro expects signals named clk and rst in the using scope.
`ifndef SPIRAL_MATRIX_READOUT_ASSERT_SVH
`define SPIRAL_MATRIX_READOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/smr_pkg.sv
`default_nettype none

package smr_pkg;

  // Defaults for the top-level size parameters
  localparam int unsigned MAX_ROWS_DEF    = 16;
  localparam int unsigned MAX_COLUMNS_DEF = 16;

  // Fixed field widths
  localparam int unsigned SIZE_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [SIZE_W-1:0] ROW_COUNT_RST    = 5'd16;
  localparam logic [SIZE_W-1:0] COLUMN_COUNT_RST = 5'd16;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // One classified item on its way from front to back
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         column;
    logic                     final_flag;
  } entry_t;

  // Size register to size in use: zero reads as one, clamp at the limit
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v,
                                           input int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > lim) begin
      return lim;
    end
    return int'(v);
  endfunction

endpackage

`default_nettype wire

>>> design/smr_cmd_if.sv
`default_nettype none

interface smr_cmd_if
  import smr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, output op, output element_value, input ready);
  modport sink   (input valid, input op, input element_value, output ready);
endinterface

`default_nettype wire

>>> design/smr_result_if.sv
`default_nettype none

interface smr_result_if
  import smr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_column;
  logic                     final_flag;

  modport source (output valid, output out_value, output out_row, output out_column,
                  output final_flag, input ready);
  modport sink   (input valid, input out_value, input out_row, input out_column,
                  input final_flag, output ready);
endinterface

`default_nettype wire

>>> design/smr_ram.sv
`default_nettype none

module smr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

`default_nettype wire

>>> design/smr_queue.sv
`default_nettype none

module smr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != NW'(DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= NW'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= NW'(fill - 1'b1);
      end
    end
  end
endmodule

`default_nettype wire

>>> design/smr_front.sv
`default_nettype none

module smr_front
  import smr_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [SIZE_W-1:0]       cfg_data,
  smr_cmd_if.sink                      cmd,
  input  wire logic                    clearing,
  input  wire logic                    q_ready,
  output logic                         q_valid,
  output entry_t                       q_entry,
  output logic [(MAX_ROWS * MAX_COLUMNS > 1 ? $clog2(MAX_ROWS * MAX_COLUMNS) : 1)-1:0] q_addr
);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ERW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned ECW   = $clog2(MAX_COLUMNS + 1);

  logic [SIZE_W-1:0] row_count, row_count_next;
  logic [SIZE_W-1:0] column_count, column_count_next;
  logic [AW-1:0]     load_pointer, load_pointer_next;
  logic [RW-1:0]     top_bound, top_bound_next;
  logic [RW-1:0]     bottom_bound, bottom_bound_next;
  logic [CW-1:0]     left_bound, left_bound_next;
  logic [CW-1:0]     right_bound, right_bound_next;
  dir_t              walk_direction, walk_direction_next;
  logic [RW-1:0]     current_row, current_row_next;
  logic [CW-1:0]     current_column, current_column_next;
  logic [NW-1:0]     emitted_count, emitted_count_next;

  logic              cfg_hit;
  logic              accept;
  logic              is_read;
  logic              last;
  logic [ERW-1:0]    eff_rows, eff_rows_rs;
  logic [ECW-1:0]    eff_cols, eff_cols_rs;
  logic [NW-1:0]     total;
  logic [AW-1:0]     read_addr;
  logic [NW-1:0]     load_inc;

  // Sizes in use and derived address
  assign eff_rows  = ERW'(eff_size(row_count, MAX_ROWS));
  assign eff_cols  = ECW'(eff_size(column_count, MAX_COLUMNS));
  assign total     = NW'(NW'(eff_rows) * NW'(eff_cols));
  assign read_addr = AW'(AW'(current_row) * AW'(eff_cols) + AW'(current_column));
  assign last      = (NW'(emitted_count + 1'b1) >= total);
  assign load_inc  = NW'(NW'(load_pointer) + 1'b1);

  // Handshake and classification
  assign cmd.ready = !clearing && q_ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_read   = (op_t'(cmd.op) == OP_READ);
  assign q_valid   = accept;

  always_comb begin
    q_entry.op         = op_t'(cmd.op);
    q_entry.value      = cmd.element_value;
    q_entry.row        = POS_W'(current_row);
    q_entry.column     = POS_W'(current_column);
    q_entry.final_flag = is_read && last;
    q_addr             = is_read ? read_addr : load_pointer;
  end

  // Register writes
  always_comb begin
    row_count_next    = row_count;
    column_count_next = column_count;
    cfg_hit           = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          row_count_next = cfg_data;
          cfg_hit        = 1'b1;
        end
        REG_COLUMN_COUNT: begin
          column_count_next = cfg_data;
          cfg_hit           = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Restart values follow the sizes after any register write
  assign eff_rows_rs = ERW'(eff_size(row_count_next, MAX_ROWS));
  assign eff_cols_rs = ECW'(eff_size(column_count_next, MAX_COLUMNS));

  // Load pointer and spiral walk
  always_comb begin
    load_pointer_next   = load_pointer;
    top_bound_next      = top_bound;
    bottom_bound_next   = bottom_bound;
    left_bound_next     = left_bound;
    right_bound_next    = right_bound;
    walk_direction_next = walk_direction;
    current_row_next    = current_row;
    current_column_next = current_column;
    emitted_count_next  = emitted_count;
    if (cfg_hit || (accept && is_read && last)) begin
      top_bound_next      = '0;
      bottom_bound_next   = RW'(eff_rows_rs - 1'b1);
      left_bound_next     = '0;
      right_bound_next    = CW'(eff_cols_rs - 1'b1);
      walk_direction_next = DIR_RIGHT;
      current_row_next    = '0;
      current_column_next = '0;
      emitted_count_next  = '0;
      if (cfg_hit) begin
        load_pointer_next = '0;
      end
    end else if (accept && !is_read) begin
      load_pointer_next = (load_inc >= total) ? '0 : AW'(load_inc);
    end else if (accept) begin
      emitted_count_next = NW'(emitted_count + 1'b1);
      case (walk_direction)
        DIR_RIGHT: begin
          if (current_column < right_bound) begin
            current_column_next = CW'(current_column + 1'b1);
          end else begin
            top_bound_next      = RW'(top_bound + 1'b1);
            walk_direction_next = DIR_DOWN;
            current_row_next    = RW'(current_row + 1'b1);
          end
        end
        DIR_DOWN: begin
          if (current_row < bottom_bound) begin
            current_row_next = RW'(current_row + 1'b1);
          end else begin
            right_bound_next    = CW'(right_bound - 1'b1);
            walk_direction_next = DIR_LEFT;
            current_column_next = CW'(current_column - 1'b1);
          end
        end
        DIR_LEFT: begin
          if (current_column > left_bound) begin
            current_column_next = CW'(current_column - 1'b1);
          end else begin
            bottom_bound_next   = RW'(bottom_bound - 1'b1);
            walk_direction_next = DIR_UP;
            current_row_next    = RW'(current_row - 1'b1);
          end
        end
        default: begin
          if (current_row > top_bound) begin
            current_row_next = RW'(current_row - 1'b1);
          end else begin
            left_bound_next     = CW'(left_bound + 1'b1);
            walk_direction_next = DIR_RIGHT;
            current_column_next = CW'(current_column + 1'b1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= ROW_COUNT_RST;
      column_count   <= COLUMN_COUNT_RST;
      load_pointer   <= '0;
      top_bound      <= '0;
      bottom_bound   <= RW'(eff_size(ROW_COUNT_RST, MAX_ROWS) - 1);
      left_bound     <= '0;
      right_bound    <= CW'(eff_size(COLUMN_COUNT_RST, MAX_COLUMNS) - 1);
      walk_direction <= DIR_RIGHT;
      current_row    <= '0;
      current_column <= '0;
      emitted_count  <= '0;
    end else begin
      row_count      <= row_count_next;
      column_count   <= column_count_next;
      load_pointer   <= load_pointer_next;
      top_bound      <= top_bound_next;
      bottom_bound   <= bottom_bound_next;
      left_bound     <= left_bound_next;
      right_bound    <= right_bound_next;
      walk_direction <= walk_direction_next;
      current_row    <= current_row_next;
      current_column <= current_column_next;
      emitted_count  <= emitted_count_next;
    end
  end
endmodule

`default_nettype wire

>>> design/smr_back.sv
`default_nettype none

module smr_back
  import smr_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire entry_t q_entry,
  input  wire logic [(MAX_ROWS * MAX_COLUMNS > 1 ? $clog2(MAX_ROWS * MAX_COLUMNS) : 1)-1:0] q_addr,
  output logic        clearing,
  smr_result_if.source result
);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW-1:0]     clr_addr;
  logic              out_valid;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_column;
  logic              out_final;
  logic              take;
  logic              take_read;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic [DATA_W-1:0] ram_rd_data;

  // Outside the clearing pass a load always drains; a read needs the output slot free or being taken
  assign q_ready   = !clearing &&
                     ((q_entry.op == OP_LOAD) || !out_valid || result.ready);
  assign take      = q_valid && q_ready;
  assign take_read = take && (q_entry.op == OP_READ);

  // Write port shared by the clearing pass and loads
  always_comb begin
    ram_wr_en   = clearing || (take && (q_entry.op == OP_LOAD));
    ram_wr_addr = clearing ? clr_addr : q_addr;
    ram_wr_data = clearing ? '0 : q_entry.value;
  end

  smr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (take_read),
    .rd_addr (q_addr),
    .rd_data (ram_rd_data)
  );

  // Clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  // Output slot; the value sits in the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_read) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_read) begin
      out_row    <= q_entry.row;
      out_column <= q_entry.column;
      out_final  <= q_entry.final_flag;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_value  = ram_rd_data;
  assign result.out_row    = out_row;
  assign result.out_column = out_column;
  assign result.final_flag = out_final;
endmodule

`default_nettype wire

>>> design/spiral_matrix_readout.sv
// A read result passes through the decoupling queue and the RAM read register; loads give no result.
// Throughput: one item per cycle, loads and reads mixed, while the output is taken;
// the single-port use of the element RAM (one load write or one read per cycle) sets it.
// Reset: synchronous, active high; afterwards a clearing pass zeroes all MAX_ROWS*MAX_COLUMNS entries
// (256 by default) of the element RAM, with no input accepted meanwhile.
`default_nettype none

module spiral_matrix_readout
  import smr_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]      cfg_data,
  smr_cmd_if.sink                     cmd,
  smr_result_if.source                result
);
  `include "spiral_matrix_readout_assert.svh"

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QW    = $bits(entry_t) + AW;

  logic          clearing;
  logic          fq_valid;
  logic          fq_ready;
  entry_t        fq_entry;
  logic [AW-1:0] fq_addr;
  logic          bq_valid;
  logic          bq_ready;
  entry_t        bq_entry;
  logic [AW-1:0] bq_addr;
  logic [QW-1:0] bq_data;

  // Front: accept, classify, walk the spiral
  smr_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .clearing  (clearing),
    .q_ready   (fq_ready),
    .q_valid   (fq_valid),
    .q_entry   (fq_entry),
    .q_addr    (fq_addr)
  );

  // Decoupling queue
  smr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   ({fq_entry, fq_addr}),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  assign {bq_entry, bq_addr} = bq_data;

  // Back: element store access and result slot
  smr_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_entry  (bq_entry),
    .q_addr   (bq_addr),
    .clearing (clearing),
    .result   (result)
  );

  // Checks
  `SMR_ASSERT_SAME(a_no_accept_while_clearing, cmd.valid && cmd.ready, !clearing,
                   "input transfer during clearing pass")
  `SMR_ASSERT_SAME(a_no_pop_while_clearing, bq_valid && bq_ready, !clearing,
                   "queue drained during clearing pass")
  `SMR_ASSERT_NEXT(a_read_gives_result, bq_valid && bq_ready && (bq_entry.op == OP_READ),
                   result.valid, "popped read did not produce a result")
  `SMR_ASSERT_SAME(a_load_no_final, fq_valid && (fq_entry.op == OP_LOAD),
                   !fq_entry.final_flag, "load entry carries final flag")
endmodule

`default_nettype wire
